@@ hw/rtl/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the parity selective stack
// Stack geometry, operation and status codes, controller command bundle.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CNT_OUT_W   = 5;

	typedef enum logic [1:0] {
		OP_PUSH      = 2'd0,
		OP_POP       = 2'd1,
		OP_DROP_ODD  = 2'd2,
		OP_DROP_EVEN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE          = 2'd0,
		ST_EMPTY_OR_MISS = 2'd1,
		ST_FULL          = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_UPDATE = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch request and run the parity scan
		logic commit;   // apply the stack update and load the result register
	} ctrl_cmd_t;

endpackage

@@ hw/rtl/pss_req_if.sv @@
// ----------------------------------------------------------------------------
// pss_req_if: request channel
// Valid/ready handshake carrying one stack operation.
// ----------------------------------------------------------------------------
interface pss_req_if;
	logic                            valid;
	logic                            ready;
	pss_pkg::op_t                    op;
	logic signed [pss_pkg::VAL_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface

@@ hw/rtl/pss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pss_rsp_if: response channel
// Valid/ready handshake carrying status, peek value, empty flag and count.
// ----------------------------------------------------------------------------
interface pss_rsp_if;
	logic                                valid;
	logic                                ready;
	pss_pkg::status_t                    status;
	logic signed [pss_pkg::VAL_W-1:0]     top_value;
	logic                                is_empty;
	logic [pss_pkg::CNT_OUT_W-1:0]       entry_count;

	modport source (output valid, output status, output top_value, output is_empty,
		output entry_count, input ready);
	modport sink   (input valid, input status, input top_value, input is_empty,
		input entry_count, output ready);
endinterface

@@ hw/rtl/pss_ctrl.sv @@
// ----------------------------------------------------------------------------
// pss_ctrl: request sequencer
// Two-state controller; owns the request ready and the response valid flag.
// ----------------------------------------------------------------------------
module pss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output pss_pkg::ctrl_cmd_t cmd
);
	import pss_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		req_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				// hold until the result register is free or being drained
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ hw/rtl/pss_datapath.sv @@
// ----------------------------------------------------------------------------
// pss_datapath: stack storage, parity scan and shift-down
// Entry registers with per-entry shift, request latch and result register.
// ----------------------------------------------------------------------------
module pss_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pss_pkg::ctrl_cmd_t                cmd,
	input  pss_pkg::op_t                      op,
	input  logic signed [pss_pkg::VAL_W-1:0]  push_value,
	output pss_pkg::status_t                  status,
	output logic signed [pss_pkg::VAL_W-1:0]  top_value,
	output logic                              is_empty,
	output logic [pss_pkg::CNT_OUT_W-1:0]     entry_count
);
	import pss_pkg::*;

	logic [VAL_W-1:0] entries_q [STACK_DEPTH];
	logic [VAL_W-1:0] above     [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;

	op_t              op_q;
	logic [VAL_W-1:0] value_q;
	logic             hit_q;
	logic [IDX_W-1:0] pos_q;

	logic             scan_hit;
	logic [IDX_W-1:0] scan_pos;
	logic             want_odd;

	status_t          res_status;
	logic [CNT_W-1:0] nxt_count;
	logic             push_en;
	logic             shift_en;
	logic [IDX_W-1:0] rd_idx;
	logic [VAL_W-1:0] res_top;

	status_t          status_q;
	logic [VAL_W-1:0] top_q;
	logic             empty_q;
	logic [CNT_W-1:0] cnt_out_q;

	// topmost live entry of the wanted parity; higher index wins
	always_comb begin
		want_odd = (op == OP_DROP_ODD);
		scan_hit = 1'b0;
		scan_pos = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if ((CNT_W'(i) < count_q) && (entries_q[i][0] == want_odd)) begin
				scan_hit = 1'b1;
				scan_pos = IDX_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < STACK_DEPTH - 1; i++) begin
			above[i] = entries_q[i + 1];
		end
		above[STACK_DEPTH-1] = entries_q[STACK_DEPTH-1];
	end

	// next count, status and the single read index for the new top
	always_comb begin
		res_status = ST_DONE;
		nxt_count  = count_q;
		push_en    = 1'b0;
		shift_en   = 1'b0;
		rd_idx     = IDX_W'(count_q - CNT_W'(1));
		if (op_q == OP_PUSH) begin
			if (count_q == CNT_W'(STACK_DEPTH)) begin
				res_status = ST_FULL;
			end else begin
				push_en   = 1'b1;
				nxt_count = count_q + CNT_W'(1);
			end
		end else if (count_q == '0) begin
			res_status = ST_EMPTY_OR_MISS;
		end else if (op_q == OP_POP) begin
			nxt_count = count_q - CNT_W'(1);
			rd_idx    = IDX_W'(count_q - CNT_W'(2));
		end else if (op_q inside {OP_DROP_ODD, OP_DROP_EVEN}) begin
			if (!hit_q) begin
				res_status = ST_EMPTY_OR_MISS;
			end else begin
				shift_en  = 1'b1;
				nxt_count = count_q - CNT_W'(1);
				if (pos_q == IDX_W'(count_q - CNT_W'(1))) begin
					rd_idx = IDX_W'(count_q - CNT_W'(2));
				end
			end
		end
		if (nxt_count == '0) begin
			res_top = '0;
		end else if (push_en) begin
			res_top = value_q;
		end else begin
			res_top = entries_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			value_q <= push_value;
			hit_q   <= scan_hit;
			pos_q   <= scan_pos;
		end
		if (cmd.commit) begin
			status_q  <= res_status;
			top_q     <= res_top;
			empty_q   <= (nxt_count == '0);
			cnt_out_q <= nxt_count;
			for (int i = 0; i < STACK_DEPTH; i++) begin
				if (shift_en && (IDX_W'(i) >= pos_q)) begin
					entries_q[i] <= above[i];
				end
				if (push_en && (IDX_W'(i) == count_q[IDX_W-1:0])) begin
					entries_q[i] <= value_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= nxt_count;
		end
	end

	assign status      = status_q;
	assign top_value   = signed'(top_q);
	assign is_empty    = empty_q;
	assign entry_count = CNT_OUT_W'(cnt_out_q);

endmodule

@@ hw/rtl/parity_selective_stack.sv @@
// ----------------------------------------------------------------------------
// parity_selective_stack: bounded LIFO with remove-topmost-odd/even
// Flow: a request is latched and scanned on acceptance; the update state then
//   commits the stack and loads the result register, which raises response valid.
// A new request is not taken until the previous one has committed: the parity
//   scan on acceptance and the shift-down/commit in the update state lie between.
// A waiting response does not block the next request until its commit cycle.
// Reset: arst_n clears the count and the handshake state; entries are not cleared.
// ----------------------------------------------------------------------------
module parity_selective_stack (
	input  logic       clk,
	input  logic       arst_n,
	pss_req_if.sink    req,
	pss_rsp_if.source  rsp
);
	import pss_pkg::*;

	ctrl_cmd_t cmd;

	// controller: sequences accept -> commit and owns the response valid
	pss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: entry registers, parity scan on capture, shift-down on commit
	pss_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (req.op),
		.push_value  (req.push_value),
		.status      (rsp.status),
		.top_value   (rsp.top_value),
		.is_empty    (rsp.is_empty),
		.entry_count (rsp.entry_count)
	);

	// a capture is always followed by a cycle with the request side closed
	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !req.ready)
		else $error("request accepted during update cycle");

	// a commit always presents a response on the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("commit did not raise response valid");

	// a dropped push only happens on a full stack
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |->
		(rsp.entry_count == CNT_OUT_W'(STACK_DEPTH)))
		else $error("full status with stack not full");

	// empty flag and count agree, and an empty stack peeks zero
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.is_empty == (rsp.entry_count == '0)) &&
		(!rsp.is_empty || rsp.top_value == '0)))
		else $error("empty flag, count and peek disagree");

endmodule

@@ verif/parity_selective_stack_tb.sv @@
// ----------------------------------------------------------------------------
// parity_selective_stack_tb: self-checking bench for the parity selective stack
// Drives push, pop and remove-topmost-odd/even requests in random bursts and
// compares every response with a bit-accurate stack predictor.
// ----------------------------------------------------------------------------
module parity_selective_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pss_pkg::*;

	localparam int RANDOM_REQUESTS = 1750;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] push_value;
	} stack_request_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] top_value;
		logic                    is_empty;
		logic [CNT_OUT_W-1:0]    entry_count;
	} stack_reply_t;

	// response-side stall patterns
	typedef enum logic [1:0] {
		RX_OPEN   = 2'd0,
		RX_LIGHT  = 2'd1,
		RX_HALF   = 2'd2,
		RX_SPARSE = 2'd3
	} rx_mode_t;

	// value flavors for random pushes
	typedef enum logic [1:0] {
		LEAN_NONE = 2'd0,
		LEAN_EVEN = 2'd1,
		LEAN_ODD  = 2'd2
	} parity_lean_t;

	logic clk;
	logic arst_n;

	pss_req_if req_ch ();
	pss_rsp_if rsp_ch ();

	parity_selective_stack i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted stack contents; index 0 is the bottom
	logic signed [VAL_W-1:0] model_words [STACK_DEPTH];
	int unsigned             model_depth;

	stack_request_t pending_requests [$];
	stack_reply_t   replies_due [$];
	stack_request_t next_request;
	stack_reply_t   oldest_reply;

	int unsigned total_requests;
	int unsigned accepted_requests;
	int unsigned error_count;
	int unsigned idle_cycles;

	int unsigned burst_left;
	int unsigned gap_left;
	bit          gapless_phase;
	int unsigned gapless_left;

	rx_mode_t    rx_mode;
	int unsigned rx_phase_left;
	int unsigned rx_tick;

	always #6 clk = ~clk;

	// Apply one request to the predicted stack and return the response it causes.
	function automatic stack_reply_t apply_stack_request(stack_request_t rq);
		stack_reply_t rp;
		int           pos;
		logic         want_bit;
		rp = '0;
		rp.status = ST_DONE;
		if (rq.op == OP_PUSH) begin
			if (model_depth >= STACK_DEPTH) begin
				rp.status = ST_FULL;
			end else begin
				model_words[model_depth] = rq.push_value;
				model_depth++;
			end
		end else if (model_depth == 0) begin
			rp.status = ST_EMPTY_OR_MISS;
		end else if (rq.op == OP_POP) begin
			model_depth--;
		end else begin
			// scan down from the top for the first word with the wanted low bit
			want_bit = (rq.op == OP_DROP_ODD);
			pos = int'(model_depth) - 1;
			while (pos >= 0 && model_words[pos][0] != want_bit)
				pos--;
			if (pos < 0) begin
				rp.status = ST_EMPTY_OR_MISS;
			end else begin
				for (int i = pos; i + 1 < int'(model_depth); i++)
					model_words[i] = model_words[i + 1];
				model_depth--;
			end
		end
		rp.top_value   = (model_depth > 0) ? model_words[model_depth - 1] : '0;
		rp.is_empty    = (model_depth == 0);
		rp.entry_count = model_depth[CNT_OUT_W-1:0];
		return rp;
	endfunction

	// Queue one request for the driver.
	function automatic void queue_request(op_t op, logic signed [VAL_W-1:0] value);
		stack_request_t rq;
		rq.op         = op;
		rq.push_value = value;
		pending_requests.push_back(rq);
		total_requests++;
	endfunction

	// Request driver: bursts of random length separated by random gaps, with
	// occasional gapless stretches. Advance only once the current transaction
	// has been taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			burst_left    <= 0;
			gap_left      <= 0;
			gapless_phase <= 1'b0;
			gapless_left  <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (gapless_left == 0) begin
				gapless_phase <= ($urandom_range(3) == 0);
				gapless_left  <= $urandom_range(20, 120);
			end else begin
				gapless_left <= gapless_left - 1;
			end
			if (gap_left > 0 || pending_requests.size() == 0) begin
				req_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				next_request = pending_requests.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.op         <= next_request.op;
				req_ch.push_value <= next_request.push_value;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= gapless_phase ? 0 : $urandom_range(0, 6);
				end
			end
		end
	end

	// Response stall pattern: switch mode at the end of each randomly long phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready  <= 1'b0;
			rx_mode       <= RX_OPEN;
			rx_phase_left <= 0;
			rx_tick       <= 0;
		end else begin
			rx_tick <= rx_tick + 1;
			if (rx_phase_left == 0) begin
				rx_mode       <= rx_mode_t'($urandom_range(3));
				rx_phase_left <= $urandom_range(20, 80);
			end else begin
				rx_phase_left <= rx_phase_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   rsp_ch.ready <= 1'b1;
				RX_LIGHT:  rsp_ch.ready <= ($urandom_range(3) != 0);
				RX_HALF:   rsp_ch.ready <= ($urandom_range(1) == 0);
				default:   rsp_ch.ready <= (rx_tick % 5 == 0);
			endcase
		end
	end

	// Monitor: predict on every accepted request, check every accepted response
	// against the oldest prediction, and count cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				replies_due.push_back(apply_stack_request('{op: req_ch.op,
					push_value: req_ch.push_value}));
				accepted_requests++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: response with nothing expected (status %0d top %0d)",
						$time, rsp_ch.status, rsp_ch.top_value);
					error_count++;
				end else begin
					oldest_reply = replies_due.pop_front();
					if (rsp_ch.status !== oldest_reply.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, oldest_reply.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.top_value !== oldest_reply.top_value) begin
						$display("%0t: top_value expected %0d got %0d",
							$time, oldest_reply.top_value, rsp_ch.top_value);
						error_count++;
					end
					if (rsp_ch.is_empty !== oldest_reply.is_empty) begin
						$display("%0t: is_empty expected %0b got %0b",
							$time, oldest_reply.is_empty, rsp_ch.is_empty);
						error_count++;
					end
					if (rsp_ch.entry_count !== oldest_reply.entry_count) begin
						$display("%0t: entry_count expected %0d got %0d",
							$time, oldest_reply.entry_count, rsp_ch.entry_count);
						error_count++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned          push_pct;
		int unsigned          phase_left;
		parity_lean_t         lean;
		op_t                  rand_op;
		logic signed [VAL_W-1:0] value;

		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_PUSH;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		model_depth       = 0;
		total_requests    = 0;
		accepted_requests = 0;
		error_count       = 0;
		idle_cycles       = 0;
		push_pct          = 50;
		phase_left        = 0;
		lean              = LEAN_NONE;

		// Directed: every removal on an empty stack
		queue_request(OP_POP, $urandom());
		queue_request(OP_DROP_ODD, $urandom());
		queue_request(OP_DROP_EVEN, $urandom());
		// Push the value extremes, negatives of both parities among them
		queue_request(OP_PUSH, 32'sh8000_0000);
		queue_request(OP_PUSH, 32'sh7FFF_FFFF);
		queue_request(OP_PUSH, -32'sd1);
		queue_request(OP_PUSH, 32'sd0);
		queue_request(OP_PUSH, 32'sd1);
		queue_request(OP_PUSH, -32'sd2);
		// Remove topmost odd/even words; the first is below the top so the words above shift down
		queue_request(OP_DROP_ODD, $urandom());
		queue_request(OP_DROP_EVEN, $urandom());
		queue_request(OP_DROP_EVEN, $urandom());
		queue_request(OP_DROP_ODD, $urandom());
		queue_request(OP_DROP_ODD, $urandom());
		// Only the most negative word is left, which is even: odd removal misses
		queue_request(OP_DROP_ODD, $urandom());
		queue_request(OP_POP, $urandom());
		// Single odd negative word: even removal misses, odd removal empties
		queue_request(OP_PUSH, -32'sd3);
		queue_request(OP_DROP_EVEN, $urandom());
		queue_request(OP_DROP_ODD, $urandom());

		// Random: phases with a push bias, so the stack swings between empty
		// and full, and a parity lean, so selective removals also miss.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (phase_left == 0) begin
				case ($urandom_range(4))
					0:       push_pct = 15;
					1:       push_pct = 35;
					2:       push_pct = 50;
					3:       push_pct = 70;
					default: push_pct = 90;
				endcase
				lean       = parity_lean_t'($urandom_range(2));
				phase_left = $urandom_range(30, 60);
			end else begin
				phase_left--;
			end
			case ($urandom_range(9))
				0, 1, 2, 3: value = $urandom();
				4, 5:       value = $signed($urandom_range(7)) - 4;
				6: begin
					case ($urandom_range(3))
						0:       value = 32'sh8000_0000;
						1:       value = 32'sh7FFF_FFFF;
						2:       value = -32'sd1;
						default: value = 32'sd0;
					endcase
				end
				default:    value = -$signed({1'b0, 31'($urandom_range(1000))});
			endcase
			if (lean == LEAN_EVEN)
				value[0] = 1'b0;
			else if (lean == LEAN_ODD)
				value[0] = 1'b1;
			if ($urandom_range(99) < push_pct)
				rand_op = OP_PUSH;
			else
				rand_op = op_t'($urandom_range(1, 3));
			queue_request(rand_op, value);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until every request is taken and every response checked, then drain.
		while (accepted_requests < total_requests || replies_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
